FILE: rtl/mwmc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mwmc_pkg: shared types and constants for the multi-window predictor
// Field types, sequencer states, window lengths and small helper functions.
// ============================================================================
package mwmc_pkg;

    localparam int SYM_W     = 8;
    localparam int BITS_W    = 4;
    localparam int ALPH_W    = SYM_W + 1;
    localparam int CTR_W     = 32;
    localparam int CNT_W     = 12;
    localparam int POS_W     = 32;
    localparam int WIN_W     = 2;
    localparam int NUM_WIN   = 4;
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW   = 12;
    localparam int TBL_AW    = WIN_W + SYM_W;
    localparam int TBL_DEPTH = 1 << TBL_AW;

    localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [CTR_W-1:0]  PRED_START  = 32'd63;
    localparam logic [CTR_W-1:0]  MIN_SYMBOLS = 32'd4096;
    localparam logic [BITS_W-1:0] MAX_SYMBOL_BITS = 4'd8;
    localparam logic [BITS_W-1:0] RESET_SYMBOL_BITS = 4'd8;
    localparam logic [WIN_W-1:0]  WIN_LAST = WIN_W'(NUM_WIN - 1);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } in_t;

    typedef struct packed {
        logic             prediction_made;
        logic [SYM_W-1:0] predicted_symbol;
        logic             hit;
        logic [CTR_W-1:0] correct_count;
        logic [CTR_W-1:0] longest_run;
        logic [CTR_W-1:0] prediction_count;
        logic             too_short;
    } out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRED,
        ST_SCORE,
        ST_WIN,
        ST_RD_OLD,
        ST_DEC_OLD,
        ST_RD_SYM,
        ST_INC_SYM,
        ST_SCAN,
        ST_FIN
    } state_t;

    function automatic logic [HIST_AW-1:0] win_len(input logic [WIN_W-1:0] j);
        logic [HIST_AW-1:0] len;
        case (j)
            2'd0:    len = 12'd63;
            2'd1:    len = 12'd255;
            2'd2:    len = 12'd1023;
            default: len = 12'd4095;
        endcase
        return len;
    endfunction

    function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] b);
        logic [BITS_W-1:0] r;
        if (b == '0)
            r = BITS_W'(1);
        else if (b > MAX_SYMBOL_BITS)
            r = MAX_SYMBOL_BITS;
        else
            r = b;
        return r;
    endfunction

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
        return (v == {CTR_W{1'b1}}) ? v : v + CTR_W'(1);
    endfunction

endpackage

FILE: rtl/multi_window_most_common_predictor_core.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_window_most_common_predictor_core: multi-window most-common predictor
// Top level: symbol width register, sequencer and the result register.
// ============================================================================
// One item is processed at a time. Each item passes through the prediction
// step, the scoring of the four windows and a count and position update for
// each window, which once the window is full also removes the symbol that
// leaves it; for every window whose most common symbol drops out, a rescan
// reads the alphabet's entries of the count and position tables one entry
// per cycle. After reset and after every item marked last, a clearing pass
// zeroes all 1024 entries of those tables before the next item is taken;
// symbol_bits writes are accepted at any time and apply from the next item
// taken.
module multi_window_most_common_predictor_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  mwmc_pkg::in_t               in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output mwmc_pkg::out_t              out_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mwmc_pkg::BITS_W-1:0] cfg_data
);

    logic [mwmc_pkg::BITS_W-1:0] symbol_bits_reg;
    logic                        out_valid_reg;
    mwmc_pkg::out_t              out_item_reg;
    logic                        res_free;
    logic                        res_push;
    mwmc_pkg::out_t              res;

    assign cfg_ready = 1'b1;
    assign res_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    mwmc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .symbol_bits (symbol_bits_reg),
        .res_free    (res_free),
        .res_push    (res_push),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_bits_reg <= mwmc_pkg::RESET_SYMBOL_BITS;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                symbol_bits_reg <= cfg_data;
            if (res_push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            out_item_reg <= res;
    end

`ifndef ASSERT_OFF
    // The sequencer holds off new items while one is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while the sequencer was busy");

    // A hit can only be reported together with a prediction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.hit |-> out_item.prediction_made)
        else $error("hit without a prediction");

    // Hits never outnumber predictions, and the best run never exceeds hits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.correct_count <= out_item.prediction_count) &&
                      (out_item.longest_run <= out_item.correct_count))
        else $error("hit counters out of order");

    // A result is never pushed over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !(out_valid && out_stall))
        else $error("result overwritten");
`endif

endmodule

FILE: rtl/mwmc_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// mwmc_ram: simple dual-port RAM
// One write port and one read port with registered read data (old data on
// a same-address collision).
// ============================================================================
module mwmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/mwmc_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// mwmc_seq: sequencer and shared datapath of the predictor
// Walks each item through prediction, scoreboard and per-window table
// updates, with a one-symbol-per-cycle rescan when a top symbol leaves.
// ============================================================================
module mwmc_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mwmc_pkg::in_t                 in_item,
    input  logic [mwmc_pkg::BITS_W-1:0]   symbol_bits,
    input  logic                          res_free,
    output logic                          res_push,
    output mwmc_pkg::out_t                res
);

    mwmc_pkg::state_t state_reg, state_next;

    logic [mwmc_pkg::WIN_W-1:0]   j_reg, j_next;
    logic [mwmc_pkg::SYM_W-1:0]   sym_reg, sym_next;
    logic                         last_reg, last_next;
    logic [mwmc_pkg::ALPH_W-1:0]  alph_reg, alph_next;
    logic [mwmc_pkg::CTR_W-1:0]   idx_reg, idx_next;
    logic [mwmc_pkg::HIST_AW-1:0] hptr_reg, hptr_next;
    logic [mwmc_pkg::CTR_W-1:0]   hits_reg, hits_next;
    logic [mwmc_pkg::CTR_W-1:0]   run_reg, run_next;
    logic [mwmc_pkg::CTR_W-1:0]   best_reg, best_next;
    logic [mwmc_pkg::CTR_W-1:0]   score_reg [mwmc_pkg::NUM_WIN];
    logic [mwmc_pkg::CTR_W-1:0]   score_next [mwmc_pkg::NUM_WIN];
    logic [mwmc_pkg::CTR_W-1:0]   win_score_reg, win_score_next;
    logic [mwmc_pkg::WIN_W-1:0]   win_reg, win_next;
    logic [mwmc_pkg::CNT_W-1:0]   top_cnt_reg [mwmc_pkg::NUM_WIN];
    logic [mwmc_pkg::CNT_W-1:0]   top_cnt_next [mwmc_pkg::NUM_WIN];
    logic [mwmc_pkg::SYM_W-1:0]   top_sym_reg [mwmc_pkg::NUM_WIN];
    logic [mwmc_pkg::SYM_W-1:0]   top_sym_next [mwmc_pkg::NUM_WIN];
    logic                         made_reg, made_next;
    logic [mwmc_pkg::SYM_W-1:0]   pred_reg, pred_next;
    logic                         hit_reg, hit_next;
    logic [mwmc_pkg::SYM_W-1:0]   old_reg, old_next;
    logic [mwmc_pkg::POS_W-1:0]   max_pos_reg, max_pos_next;
    logic [mwmc_pkg::ALPH_W-1:0]  k_reg, k_next;
    logic                         scan_vld_reg, scan_vld_next;
    logic [mwmc_pkg::SYM_W-1:0]   scan_sym_reg, scan_sym_next;
    logic [mwmc_pkg::TBL_AW-1:0]  clr_reg, clr_next;

    logic                         cnt_we, pos_we, hist_we;
    logic [mwmc_pkg::TBL_AW-1:0]  tbl_wr_addr, tbl_rd_addr;
    logic [mwmc_pkg::CNT_W-1:0]   cnt_wr_data, cnt_rd;
    logic [mwmc_pkg::POS_W-1:0]   pos_wr_data, pos_rd;
    logic [mwmc_pkg::HIST_AW-1:0] hist_rd_addr;
    logic [mwmc_pkg::SYM_W-1:0]   hist_rd;

    logic [mwmc_pkg::WIN_W-1:0]   sel_win;
    logic [mwmc_pkg::SYM_W-1:0]   top_sym_cur;
    logic [mwmc_pkg::CNT_W-1:0]   top_cnt_cur;
    logic [mwmc_pkg::CTR_W-1:0]   cur_len;
    logic                         fresh;
    logic                         rescan;
    logic                         scan_done;
    logic [mwmc_pkg::ALPH_W-1:0]  alph_in;
    logic [mwmc_pkg::CNT_W-1:0]   cnt_inc;
    logic [mwmc_pkg::CTR_W-1:0]   new_score;
    logic                         made_now;

    mwmc_ram #(.WIDTH(mwmc_pkg::CNT_W), .DEPTH(mwmc_pkg::TBL_DEPTH)) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (tbl_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (cnt_rd)
    );

    mwmc_ram #(.WIDTH(mwmc_pkg::POS_W), .DEPTH(mwmc_pkg::TBL_DEPTH)) u_pos_ram (
        .clk     (clk),
        .wr_en   (pos_we),
        .wr_addr (tbl_wr_addr),
        .wr_data (pos_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (pos_rd)
    );

    mwmc_ram #(.WIDTH(mwmc_pkg::SYM_W), .DEPTH(mwmc_pkg::HIST_DEPTH)) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (hptr_reg),
        .wr_data (sym_reg),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd)
    );

    // The prediction step looks at the winning window, every other step at
    // the window under update.
    assign sel_win     = (state_reg == mwmc_pkg::ST_PRED) ? win_reg : j_reg;
    assign top_sym_cur = top_sym_reg[sel_win];
    assign top_cnt_cur = top_cnt_reg[sel_win];
    assign cur_len     = mwmc_pkg::CTR_W'(mwmc_pkg::win_len(j_reg));
    assign fresh       = idx_reg < cur_len;
    assign rescan      = !fresh && (old_reg == top_sym_cur);
    assign scan_done   = !scan_vld_reg && (k_reg >= alph_reg);
    assign alph_in     = mwmc_pkg::ALPH_W'(1) << mwmc_pkg::eff_bits(symbol_bits);
    assign cnt_inc     = (cnt_rd == mwmc_pkg::CNT_MAX) ? cnt_rd : cnt_rd + 12'd1;
    assign new_score   = mwmc_pkg::sat_inc(score_reg[j_reg]);
    assign made_now    = idx_reg >= mwmc_pkg::PRED_START;
    assign hist_rd_addr = hptr_reg - mwmc_pkg::win_len(j_reg);

    assign in_stall = (state_reg != mwmc_pkg::ST_IDLE);

    always_comb
    begin
        res.prediction_made  = made_reg;
        res.predicted_symbol = pred_reg;
        res.hit              = hit_reg;
        res.correct_count    = hits_reg;
        res.longest_run      = best_reg;
        res.prediction_count = made_reg ?
            idx_reg - (mwmc_pkg::PRED_START - mwmc_pkg::CTR_W'(1)) : '0;
        res.too_short        = last_reg &&
            (mwmc_pkg::sat_inc(idx_reg) < mwmc_pkg::MIN_SYMBOLS);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwmc_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                    state_next = mwmc_pkg::ST_IDLE;
            end
            mwmc_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = mwmc_pkg::ST_PRED;
            end
            mwmc_pkg::ST_PRED:
            begin
                state_next = mwmc_pkg::ST_SCORE;
            end
            mwmc_pkg::ST_SCORE:
            begin
                if (j_reg == mwmc_pkg::WIN_LAST)
                    state_next = mwmc_pkg::ST_WIN;
            end
            mwmc_pkg::ST_WIN:
            begin
                state_next = fresh ? mwmc_pkg::ST_INC_SYM : mwmc_pkg::ST_RD_OLD;
            end
            mwmc_pkg::ST_RD_OLD:
            begin
                state_next = mwmc_pkg::ST_DEC_OLD;
            end
            mwmc_pkg::ST_DEC_OLD:
            begin
                state_next = mwmc_pkg::ST_RD_SYM;
            end
            mwmc_pkg::ST_RD_SYM:
            begin
                state_next = mwmc_pkg::ST_INC_SYM;
            end
            mwmc_pkg::ST_INC_SYM:
            begin
                if (rescan)
                    state_next = mwmc_pkg::ST_SCAN;
                else if (j_reg == mwmc_pkg::WIN_LAST)
                    state_next = mwmc_pkg::ST_FIN;
                else
                    state_next = mwmc_pkg::ST_WIN;
            end
            mwmc_pkg::ST_SCAN:
            begin
                if (scan_done)
                    state_next = (j_reg == mwmc_pkg::WIN_LAST) ?
                                 mwmc_pkg::ST_FIN : mwmc_pkg::ST_WIN;
            end
            mwmc_pkg::ST_FIN:
            begin
                if (res_free)
                    state_next = last_reg ? mwmc_pkg::ST_CLEAR : mwmc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mwmc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Datapath and table controls.
    always_comb
    begin
        j_next         = j_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        alph_next      = alph_reg;
        idx_next       = idx_reg;
        hptr_next      = hptr_reg;
        hits_next      = hits_reg;
        run_next       = run_reg;
        best_next      = best_reg;
        score_next     = score_reg;
        win_score_next = win_score_reg;
        win_next       = win_reg;
        top_cnt_next   = top_cnt_reg;
        top_sym_next   = top_sym_reg;
        made_next      = made_reg;
        pred_next      = pred_reg;
        hit_next       = hit_reg;
        old_next       = old_reg;
        max_pos_next   = max_pos_reg;
        k_next         = k_reg;
        scan_vld_next  = scan_vld_reg;
        scan_sym_next  = scan_sym_reg;
        clr_next       = clr_reg;
        cnt_we         = 1'b0;
        pos_we         = 1'b0;
        hist_we        = 1'b0;
        res_push       = 1'b0;
        tbl_wr_addr    = {j_reg, sym_reg};
        tbl_rd_addr    = {j_reg, sym_reg};
        cnt_wr_data    = cnt_inc;
        pos_wr_data    = idx_reg;

        case (state_reg)
            mwmc_pkg::ST_CLEAR:
            begin
                cnt_we      = 1'b1;
                pos_we      = 1'b1;
                tbl_wr_addr = clr_reg;
                cnt_wr_data = '0;
                pos_wr_data = '0;
                clr_next    = clr_reg + mwmc_pkg::TBL_AW'(1);
            end
            mwmc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next  = in_item.symbol & mwmc_pkg::SYM_W'(alph_in - 9'd1);
                    last_next = in_item.last;
                    alph_next = alph_in;
                end
            end
            mwmc_pkg::ST_PRED:
            begin
                made_next = made_now;
                pred_next = '0;
                hit_next  = 1'b0;
                j_next    = '0;
                if (made_now)
                begin
                    pred_next = top_sym_cur;
                    hit_next  = (top_sym_cur == sym_reg);
                    if (top_sym_cur == sym_reg)
                    begin
                        hits_next = mwmc_pkg::sat_inc(hits_reg);
                        run_next  = mwmc_pkg::sat_inc(run_reg);
                        if (mwmc_pkg::sat_inc(run_reg) > best_reg)
                            best_next = mwmc_pkg::sat_inc(run_reg);
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
            end
            mwmc_pkg::ST_SCORE:
            begin
                // Windows are scored in order; a later window wins a tie.
                if (made_reg && !fresh && (top_sym_cur == sym_reg))
                begin
                    score_next[j_reg] = new_score;
                    if (j_reg == win_reg || new_score >= win_score_reg)
                    begin
                        win_next       = j_reg;
                        win_score_next = new_score;
                    end
                end
                j_next = j_reg + mwmc_pkg::WIN_W'(1);
            end
            mwmc_pkg::ST_RD_OLD:
            begin
                old_next    = hist_rd;
                tbl_rd_addr = {j_reg, hist_rd};
            end
            mwmc_pkg::ST_DEC_OLD:
            begin
                cnt_we      = 1'b1;
                tbl_wr_addr = {j_reg, old_reg};
                cnt_wr_data = (cnt_rd == '0) ? cnt_rd : cnt_rd - 12'd1;
            end
            mwmc_pkg::ST_INC_SYM:
            begin
                cnt_we = 1'b1;
                pos_we = 1'b1;
                if (rescan)
                begin
                    top_cnt_next[j_reg] = (top_cnt_cur == '0) ? top_cnt_cur :
                                          top_cnt_cur - 12'd1;
                    max_pos_next  = idx_reg - cur_len;
                    k_next        = '0;
                    scan_vld_next = 1'b0;
                end
                else
                begin
                    if (cnt_inc >= top_cnt_cur)
                    begin
                        top_cnt_next[j_reg] = cnt_inc;
                        top_sym_next[j_reg] = sym_reg;
                    end
                    j_next = j_reg + mwmc_pkg::WIN_W'(1);
                end
            end
            mwmc_pkg::ST_SCAN:
            begin
                // Read data for scan_sym_reg arrives while the next symbol is
                // addressed; the best-so-far registers update whenever a read entry wins.
                if (scan_vld_reg)
                begin
                    if (cnt_rd > top_cnt_cur ||
                        (cnt_rd == top_cnt_cur && pos_rd >= max_pos_reg))
                    begin
                        top_cnt_next[j_reg] = cnt_rd;
                        top_sym_next[j_reg] = scan_sym_reg;
                        max_pos_next        = pos_rd;
                    end
                end
                if (k_reg < alph_reg)
                begin
                    tbl_rd_addr   = {j_reg, k_reg[mwmc_pkg::SYM_W-1:0]};
                    scan_vld_next = 1'b1;
                    scan_sym_next = k_reg[mwmc_pkg::SYM_W-1:0];
                    k_next        = k_reg + mwmc_pkg::ALPH_W'(1);
                end
                else
                begin
                    scan_vld_next = 1'b0;
                    if (!scan_vld_reg)
                        j_next = j_reg + mwmc_pkg::WIN_W'(1);
                end
            end
            mwmc_pkg::ST_FIN:
            begin
                if (res_free)
                begin
                    res_push  = 1'b1;
                    hist_we   = 1'b1;
                    hptr_next = hptr_reg + mwmc_pkg::HIST_AW'(1);
                    idx_next  = mwmc_pkg::sat_inc(idx_reg);
                    if (last_reg)
                    begin
                        hptr_next      = '0;
                        idx_next       = '0;
                        hits_next      = '0;
                        run_next       = '0;
                        best_next      = '0;
                        win_score_next = '0;
                        win_next       = '0;
                        for (int w = 0; w < mwmc_pkg::NUM_WIN; w++)
                        begin
                            score_next[w]   = '0;
                            top_cnt_next[w] = '0;
                            top_sym_next[w] = '0;
                        end
                    end
                end
            end
            default:
            begin
                j_next = j_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwmc_pkg::ST_CLEAR;
            j_reg         <= '0;
            last_reg      <= 1'b0;
            alph_reg      <= '0;
            idx_reg       <= '0;
            hptr_reg      <= '0;
            hits_reg      <= '0;
            run_reg       <= '0;
            best_reg      <= '0;
            win_score_reg <= '0;
            win_reg       <= '0;
            made_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            k_reg         <= '0;
            scan_vld_reg  <= 1'b0;
            clr_reg       <= '0;
            for (int w = 0; w < mwmc_pkg::NUM_WIN; w++)
            begin
                score_reg[w]   <= '0;
                top_cnt_reg[w] <= '0;
                top_sym_reg[w] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            last_reg      <= last_next;
            alph_reg      <= alph_next;
            idx_reg       <= idx_next;
            hptr_reg      <= hptr_next;
            hits_reg      <= hits_next;
            run_reg       <= run_next;
            best_reg      <= best_next;
            win_score_reg <= win_score_next;
            win_reg       <= win_next;
            made_reg      <= made_next;
            hit_reg       <= hit_next;
            k_reg         <= k_next;
            scan_vld_reg  <= scan_vld_next;
            clr_reg       <= clr_next;
            score_reg     <= score_next;
            top_cnt_reg   <= top_cnt_next;
            top_sym_reg   <= top_sym_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        pred_reg     <= pred_next;
        old_reg      <= old_next;
        max_pos_reg  <= max_pos_next;
        scan_sym_reg <= scan_sym_next;
    end

endmodule

FILE: tb/sv/mwmc_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mwmc_checker: result predictor and comparator for the predictor core
// Watches the input, output and symbol-width channels, forecasts every
// result from its own model of the four windows and compares field by field.
// ============================================================================
module mwmc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  mwmc_pkg::in_t               in_item,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  mwmc_pkg::out_t              out_item,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [mwmc_pkg::BITS_W-1:0] cfg_data,
    output int                          mismatches,
    output int                          pending
);

    localparam int unsigned WLEN [4] = '{63, 255, 1023, 4095};
    localparam int unsigned COUNT_CEIL = 4095;

    logic [mwmc_pkg::BITS_W-1:0] width_reg;
    logic [mwmc_pkg::SYM_W-1:0]  history [mwmc_pkg::HIST_DEPTH];
    int unsigned       sym_count [4][256];
    int unsigned       seen_at [4][256];
    int unsigned       lead_count [4];
    int unsigned       lead_sym [4];
    int unsigned       score [4];
    int unsigned       leader;
    int unsigned       seq_pos;
    int unsigned       hist_wr;
    int unsigned       hits;
    int unsigned       run_len;
    int unsigned       best_len;
    mwmc_pkg::out_t    expected_results [$];

    function automatic int unsigned bump(input int unsigned v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function automatic int unsigned eff_bits_local(input logic [mwmc_pkg::BITS_W-1:0] b);
        if (b == 0)
            return 1;
        if (b > mwmc_pkg::MAX_SYMBOL_BITS)
            return mwmc_pkg::MAX_SYMBOL_BITS;
        return b;
    endfunction

    task automatic restart_sequence();
        for (int w = 0; w < 4; w++)
        begin
            for (int k = 0; k < 256; k++)
            begin
                sym_count[w][k] = 0;
                seen_at[w][k] = 0;
            end
            lead_count[w] = 0;
            lead_sym[w] = 0;
            score[w] = 0;
        end
        leader = 0;
        seq_pos = 0;
        hist_wr = 0;
        hits = 0;
        run_len = 0;
        best_len = 0;
    endtask

    task automatic slide_window(input int w, input int unsigned s, input int unsigned i,
                                input int unsigned alph);
        int unsigned leaving;
        int unsigned newest;
        if (i < WLEN[w])
        begin
            if (sym_count[w][s] < COUNT_CEIL)
                sym_count[w][s]++;
            if (sym_count[w][s] >= lead_count[w])
            begin
                lead_count[w] = sym_count[w][s];
                lead_sym[w] = s;
            end
            seen_at[w][s] = i;
            return;
        end
        leaving = history[(hist_wr + mwmc_pkg::HIST_DEPTH - WLEN[w]) % mwmc_pkg::HIST_DEPTH];
        if (sym_count[w][leaving] > 0)
            sym_count[w][leaving]--;
        if (sym_count[w][s] < COUNT_CEIL)
            sym_count[w][s]++;
        seen_at[w][s] = i;
        if (leaving != lead_sym[w])
        begin
            if (sym_count[w][s] >= lead_count[w])
            begin
                lead_count[w] = sym_count[w][s];
                lead_sym[w] = s;
            end
        end
        else
        begin
            // The leader dropped out: rescan the alphabet, latest position wins ties.
            if (lead_count[w] > 0)
                lead_count[w]--;
            newest = i - WLEN[w];
            for (int unsigned k = 0; k < alph; k++)
            begin
                if (sym_count[w][k] > lead_count[w] ||
                    (sym_count[w][k] == lead_count[w] && seen_at[w][k] >= newest))
                begin
                    lead_count[w] = sym_count[w][k];
                    lead_sym[w] = k;
                    newest = seen_at[w][k];
                end
            end
        end
    endtask

    task automatic forecast(input mwmc_pkg::in_t it, output mwmc_pkg::out_t r);
        int unsigned nbits;
        int unsigned alph;
        int unsigned s;
        int unsigned i;
        nbits = eff_bits_local(width_reg);
        alph = 1 << nbits;
        s = it.symbol & (alph - 1);
        i = seq_pos;
        r = '0;
        if (i >= WLEN[0])
        begin
            r.prediction_made = 1'b1;
            r.predicted_symbol = mwmc_pkg::SYM_W'(lead_sym[leader]);
            r.hit = (lead_sym[leader] == s);
            if (r.hit)
            begin
                hits = bump(hits);
                run_len = bump(run_len);
                if (run_len > best_len)
                    best_len = run_len;
            end
            else
                run_len = 0;
            for (int w = 0; w < 4; w++)
            begin
                if (i >= WLEN[w] && lead_sym[w] == s)
                begin
                    score[w] = bump(score[w]);
                    if (score[w] >= score[leader])
                        leader = w;
                end
            end
            r.prediction_count = i - WLEN[0] + 1;
        end
        for (int w = 0; w < 4; w++)
            slide_window(w, s, i, alph);
        history[hist_wr] = mwmc_pkg::SYM_W'(s);
        hist_wr = (hist_wr + 1) % mwmc_pkg::HIST_DEPTH;
        seq_pos = bump(seq_pos);
        r.correct_count = hits;
        r.longest_run = best_len;
        if (it.last)
        begin
            r.too_short = (seq_pos < 4096);
            restart_sequence();
        end
    endtask

    task automatic compare(input string name, input longint unsigned want,
                           input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mwmc_pkg::out_t r;
        mwmc_pkg::out_t want;
        if (!rst_n)
        begin
            width_reg <= mwmc_pkg::RESET_SYMBOL_BITS;
            restart_sequence();
            expected_results.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                width_reg <= cfg_data;
            if (in_valid && !in_stall)
            begin
                forecast(in_item, r);
                expected_results.push_back(r);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item arrived with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare("prediction_made", want.prediction_made, out_item.prediction_made);
                    compare("predicted_symbol", want.predicted_symbol,
                            out_item.predicted_symbol);
                    compare("hit", want.hit, out_item.hit);
                    compare("correct_count", want.correct_count, out_item.correct_count);
                    compare("longest_run", want.longest_run, out_item.longest_run);
                    compare("prediction_count", want.prediction_count,
                            out_item.prediction_count);
                    compare("too_short", want.too_short, out_item.too_short);
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/sv/tb_multi_window_most_common_predictor_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_multi_window_most_common_predictor_core: stimulus and verdict
// Drives symbol sequences of many lengths and symbol widths, with random
// gaps and back-pressure, and lets the checker judge every result item.
// ============================================================================
module tb_multi_window_most_common_predictor_core;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 12_000_000;
    localparam int LONG_HOLD    = 3000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    mwmc_pkg::in_t               in_item;
    logic                        out_valid;
    logic                        out_stall;
    mwmc_pkg::out_t              out_item;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [mwmc_pkg::BITS_W-1:0] cfg_data;
    int                mismatches;
    int                pending;
    int                cycles = 0;
    bit                quiet;
    bit                hold_req;
    int                random_sent;

    multi_window_most_common_predictor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mwmc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("multi_window_most_common_predictor_core test failed");
            $finish;
        end
    end

    // Receiver side: random stall bursts, or one long hold-off on request.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [mwmc_pkg::SYM_W-1:0] sym, input logic last);
        if (quiet == 1'b0 && random_sent >= RANDOM_ITEMS - 150)
            quiet = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item.symbol <= sym;
        in_item.last <= last;
        do
            @(posedge clk);
        while (in_stall);
        random_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_width(input logic [mwmc_pkg::BITS_W-1:0] value);
        drain();
        repeat (16) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a few favored symbols with repeats so predictions hit; the rest is noise.
    task automatic run_sequence(input int len, input bit width_change);
        logic [mwmc_pkg::SYM_W-1:0] favored [3];
        logic [mwmc_pkg::SYM_W-1:0] sym;
        for (int f = 0; f < 3; f++)
            favored[f] = mwmc_pkg::SYM_W'($urandom);
        sym = favored[0];
        for (int k = 0; k < len; k++)
        begin
            if (width_change && !quiet && k == len / 2)
                set_width(mwmc_pkg::BITS_W'($urandom_range(0, 15)));
            case ($urandom_range(0, 9))
                0, 1, 2: sym = sym;
                3, 4, 5, 6: sym = favored[$urandom_range(0, 2)];
                default: sym = mwmc_pkg::SYM_W'($urandom);
            endcase
            send_item(sym, k == len - 1);
        end
    endtask

    initial
    begin
        int len;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        random_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, too-short sequences and out-of-range widths.
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hAA, 1'b1);
        set_width(4'd15);
        send_item(8'h55, 1'b0);
        send_item(8'hFF, 1'b1);
        set_width(4'd0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFE, 1'b0);
        send_item(8'h01, 1'b1);
        set_width(4'd1);
        send_item(8'h00, 1'b1);
        set_width(4'd8);
        send_item(8'h7F, 1'b1);

        // One long bitstring sequence slides the three shorter windows;
        // the receiver holds off partway through so the block backs up.
        set_width(4'd1);
        for (int k = 0; k < 1060; k++)
        begin
            if (k == 300)
                hold_req = 1'b1;
            send_item(mwmc_pkg::SYM_W'($urandom), k == 1059);
        end
        drain();

        while (random_sent < RANDOM_ITEMS)
        begin
            if (!quiet)
            begin
                case ($urandom_range(0, 7))
                    0: set_width(4'd0);
                    1: set_width(4'd1);
                    2: set_width(4'd8);
                    3: set_width(4'd15);
                    default: set_width(mwmc_pkg::BITS_W'($urandom_range(2, 8)));
                endcase
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 700)
                                              : $urandom_range(64, 200);
            if (len > RANDOM_ITEMS - random_sent)
                len = RANDOM_ITEMS - random_sent;
            run_sequence(len, $urandom_range(0, 3) == 0);
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("multi_window_most_common_predictor_core test passed");
        else
            $display("multi_window_most_common_predictor_core test failed");
        $finish;
    end

endmodule
